// ----- rtl/hadb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hadb_pkg: shared types and constants of the heading alignment debouncer
// Angle formats, CORDIC arctangent table, queue entry and config types.
// ----------------------------------------------------------------------------
package hadb_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int POS_WIDTH    = 32;
  localparam int ATAN_DEPTH   = 24;
  localparam int ROT_STEPS    = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;
  localparam int STEP_W       = $clog2(ATAN_DEPTH);

  localparam int FWD_W  = 17;               // negated Q1.14 element
  localparam int DIFF_W = POS_WIDTH + 1;    // position difference
  localparam int CW     = 54;               // CORDIC x/y datapath
  localparam int ZW     = 27;               // angle accumulator, Q.16 degrees
  localparam int ANG_W  = 16;
  localparam int ERR_W  = 15;
  localparam int CNT_W  = 4;
  localparam int CFG_W  = 15;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  localparam logic signed [CW-1:0] NORM_LIM     = CW'(64'sd1 <<< 49);
  localparam logic signed [CW-1:0] NEG_NORM_LIM = -NORM_LIM;

  localparam logic signed [ZW-1:0] HALF_Q16 = 27'sd11796480;   // 180 deg
  localparam logic signed [ZW-1:0] FULL_Q16 = 27'sd23592960;   // 360 deg
  localparam logic signed [ZW-1:0] RND_Q16  = 27'sd256;
  localparam logic [ANG_W-1:0]     FULL_Q7  = 16'd46080;
  localparam logic [ANG_W-1:0]     HALF_Q7  = 16'd23040;

  localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_DEPTH] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  localparam logic [ERR_W-1:0] THR_RESET = 15'd3200;
  localparam logic [CNT_W-1:0] REQ_RESET = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_THRESHOLD  = 1'b0,
    CFG_REQUIRED_MATCHES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [ERR_W-1:0] thr;
    logic [CNT_W-1:0] req;
  } cfg_t;

  typedef struct packed {
    logic                     req_type;
    logic signed [FWD_W-1:0]  fx;
    logic signed [FWD_W-1:0]  fz;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dz;
  } qent_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] a;    // sine side
    logic signed [CW-1:0] b;    // cosine side
  } cor_req_t;

  typedef struct packed {
    logic             done;
    logic [ANG_W-1:0] yaw;
  } cor_rsp_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

endpackage
`default_nettype wire

// ----- rtl/hadb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hadb_if: pose sample and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hadb_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] rot_elem_x;
  logic signed [15:0] rot_elem_z;
  logic signed [31:0] cam_x;
  logic signed [31:0] cam_z;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_z;

  modport source (output valid, req_type, rot_elem_x, rot_elem_z, cam_x, cam_z,
                  goal_x, goal_z, input ready);
  modport sink   (input valid, req_type, rot_elem_x, rot_elem_z, cam_x, cam_z,
                  goal_x, goal_z, output ready);
endinterface

interface hadb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] camera_yaw;
  logic [15:0] path_yaw;
  logic [14:0] heading_error;
  logic        aligned_pulse;
  logic        armed;
  logic [3:0]  match_count;

  modport source (output valid, camera_yaw, path_yaw, heading_error, aligned_pulse,
                  armed, match_count, input ready);
  modport sink   (input valid, camera_yaw, path_yaw, heading_error, aligned_pulse,
                  armed, match_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/hadb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hadb_front: input stage
// Accepts beats, forms the forward vector and the camera-to-goal vector.
// ----------------------------------------------------------------------------
module hadb_front (
  hadb_in_if.sink          in_ch,
  input  logic             q_full,
  output logic             q_push,
  output hadb_pkg::qent_t  q_din
);
  import hadb_pkg::*;

  logic signed [DIFF_W-1:0] cam_x_s, cam_z_s, goal_x_s, goal_z_s;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  assign cam_x_s  = $signed({in_ch.cam_x[POS_WIDTH-1],  in_ch.cam_x[POS_WIDTH-1:0]});
  assign cam_z_s  = $signed({in_ch.cam_z[POS_WIDTH-1],  in_ch.cam_z[POS_WIDTH-1:0]});
  assign goal_x_s = $signed({in_ch.goal_x[POS_WIDTH-1], in_ch.goal_x[POS_WIDTH-1:0]});
  assign goal_z_s = $signed({in_ch.goal_z[POS_WIDTH-1], in_ch.goal_z[POS_WIDTH-1:0]});

  always_comb begin
    q_din.req_type = in_ch.req_type;
    // forward vector is the negated third column
    q_din.fx = -$signed({in_ch.rot_elem_x[15], in_ch.rot_elem_x});
    q_din.fz = -$signed({in_ch.rot_elem_z[15], in_ch.rot_elem_z});
    q_din.dx = goal_x_s - cam_x_s;
    q_din.dz = goal_z_s - cam_z_s;
  end

endmodule
`default_nettype wire

// ----- rtl/hadb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hadb_queue: two-entry queue between front and back
// Decouples input acceptance from the CORDIC sequencer.
// ----------------------------------------------------------------------------
module hadb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hadb_pkg::qent_t din,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output hadb_pkg::qent_t dout
);
  import hadb_pkg::*;

  qent_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = mem_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hadb_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hadb_cordic: iterative vectoring CORDIC atan2
// Normalizes by one doubling per cycle, then one rotation per cycle.
// ----------------------------------------------------------------------------
module hadb_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  hadb_pkg::cor_req_t req,
  output hadb_pkg::cor_rsp_t rsp
);
  import hadb_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_NORM = 4'b0010,
    C_ROT  = 4'b0100,
    C_FIN  = 4'b1000
  } cst_t;

  cst_t                 st_r, st_nxt;
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [STEP_W-1:0]    i_r, i_nxt;

  logic signed [CW-1:0] x_sh, y_sh;
  logic                 in_rng;
  logic signed [ZW-1:0] z_pos, z_rnd;
  logic [ANG_W-1:0]     yaw_raw;

  assign x_sh   = x_r >>> i_r;
  assign y_sh   = y_r >>> i_r;
  assign in_rng = (x_r > NEG_NORM_LIM) && (x_r < NORM_LIM) &&
                  (y_r > NEG_NORM_LIM) && (y_r < NORM_LIM);

  // wrap to 0..360, round half up to Q9.7, fold 360 back to 0
  assign z_pos   = z_r[ZW-1] ? z_r + FULL_Q16 : z_r;
  assign z_rnd   = (z_pos + RND_Q16) >>> 9;
  assign yaw_raw = z_rnd[ANG_W-1:0];

  always_comb begin
    rsp.done = (st_r == C_FIN);
    rsp.yaw  = (yaw_raw >= FULL_Q7) ? yaw_raw - FULL_Q7 : yaw_raw;
  end

  always_comb begin
    st_nxt = st_r;
    x_nxt  = x_r;
    y_nxt  = y_r;
    z_nxt  = z_r;
    i_nxt  = i_r;
    unique case (st_r)
      C_IDLE, C_FIN: begin
        if (req.start) begin
          x_nxt  = req.b;
          y_nxt  = req.a;
          z_nxt  = '0;
          st_nxt = C_NORM;
        end else begin
          st_nxt = C_IDLE;
        end
      end
      C_NORM: begin
        if (x_r == '0 && y_r == '0) begin
          z_nxt  = '0;
          st_nxt = C_FIN;
        end else if (in_rng) begin
          x_nxt = x_r <<< 1;
          y_nxt = y_r <<< 1;
        end else begin
          if (x_r[CW-1]) begin
            x_nxt = -x_r;
            y_nxt = -y_r;
            z_nxt = HALF_Q16;
          end
          i_nxt  = '0;
          st_nxt = C_ROT;
        end
      end
      C_ROT: begin
        if (y_r > 0) begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + ATAN_TAB[i_r];
        end else begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - ATAN_TAB[i_r];
        end
        if (i_r == STEP_W'(ROT_STEPS - 1)) begin
          st_nxt = C_FIN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/hadb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hadb_back: sequencer, debounce state and output register
// Runs camera and path atan2 on the shared CORDIC, then updates the count.
// ----------------------------------------------------------------------------
module hadb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hadb_pkg::qent_t    q_head,
  output logic               q_pop,
  input  hadb_pkg::cfg_t     cfg,
  output hadb_pkg::cor_req_t cor_req,
  input  hadb_pkg::cor_rsp_t cor_rsp,
  hadb_out_if.source         out_ch
);
  import hadb_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_CAM  = 4'b0010,
    B_PATH = 4'b0100,
    B_DONE = 4'b1000
  } bst_t;

  bst_t             st_r, st_nxt;
  qent_t            item_r;
  logic [ANG_W-1:0] cy_r, py_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             armed_r, armed_nxt;

  logic             ov_r;
  logic [ANG_W-1:0] ocy_r, opy_r;
  logic [ERR_W-1:0] oerr_r;
  logic             opulse_r, oarmed_r;
  logic [CNT_W-1:0] ocnt_r;

  logic [ANG_W-1:0] diff_raw, diff_wrap;
  logic [ERR_W-1:0] err;
  logic [CNT_W-1:0] cnt_inc;
  logic             pulse;
  logic             load;

  assign load  = (st_r == B_DONE) && (!ov_r || out_ch.ready);
  assign q_pop = (st_r == B_IDLE) && q_valid;

  always_comb begin
    cor_req.start = 1'b0;
    cor_req.a     = {{(CW-FWD_W){q_head.fx[FWD_W-1]}}, q_head.fx};
    cor_req.b     = {{(CW-FWD_W){q_head.fz[FWD_W-1]}}, q_head.fz};
    if (st_r == B_IDLE) begin
      cor_req.start = q_valid && !q_head.req_type;
    end else if (st_r == B_CAM) begin
      cor_req.start = cor_rsp.done;
      cor_req.a     = {{(CW-DIFF_W){item_r.dx[DIFF_W-1]}}, item_r.dx};
      cor_req.b     = {{(CW-DIFF_W){item_r.dz[DIFF_W-1]}}, item_r.dz};
    end
  end

  // wrapped yaw error and debounce update
  always_comb begin
    diff_raw  = (cy_r > py_r) ? cy_r - py_r : py_r - cy_r;
    diff_wrap = (diff_raw > HALF_Q7) ? FULL_Q7 - diff_raw : diff_raw;
    err       = diff_wrap[ERR_W-1:0];
    cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    cnt_nxt   = cnt_r;
    armed_nxt = armed_r;
    pulse     = 1'b0;
    if (item_r.req_type) begin
      cnt_nxt   = '0;
      armed_nxt = 1'b1;
    end else if (armed_r) begin
      if (err < cfg.thr) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= cfg.req || cnt_inc == CNT_MAX) begin
          pulse     = 1'b1;
          armed_nxt = 1'b0;
        end
      end else begin
        cnt_nxt = '0;
      end
    end else if (err > cfg.thr) begin
      armed_nxt = 1'b1;
      cnt_nxt   = '0;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: begin
        if (q_valid) begin
          st_nxt = q_head.req_type ? B_DONE : B_CAM;
        end
      end
      B_CAM: begin
        if (cor_rsp.done) begin
          st_nxt = B_PATH;
        end
      end
      B_PATH: begin
        if (cor_rsp.done) begin
          st_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (load) begin
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      cnt_r   <= '0;
      armed_r <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load) begin
        cnt_r   <= cnt_nxt;
        armed_r <= armed_nxt;
        ov_r    <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_head;
      cy_r   <= '0;
      py_r   <= '0;
    end
    if (st_r == B_CAM && cor_rsp.done) begin
      cy_r <= cor_rsp.yaw;
    end
    if (st_r == B_PATH && cor_rsp.done) begin
      py_r <= cor_rsp.yaw;
    end
    if (load) begin
      ocy_r    <= cy_r;
      opy_r    <= py_r;
      oerr_r   <= err;
      opulse_r <= pulse;
      oarmed_r <= armed_nxt;
      ocnt_r   <= cnt_nxt;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.camera_yaw    = ocy_r;
  assign out_ch.path_yaw      = opy_r;
  assign out_ch.heading_error = oerr_r;
  assign out_ch.aligned_pulse = opulse_r;
  assign out_ch.armed         = oarmed_r;
  assign out_ch.match_count   = ocnt_r;

endmodule
`default_nettype wire

// ----- rtl/heading_alignment_debouncer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sequence: the back takes a queued pose beat and runs the forward vector, then the
//   path vector, through the shared CORDIC; each is normalized by doublings and then
//   turned by ROT = 16 CORDIC rotations, and a zero vector skips both steps; a reset
//   request skips the CORDIC. The back takes no new beat until the last one is loaded.
// Sharing: both yaws use the single shared CORDIC unit; the queue holds up to two beats.
// Reset: synchronous active-low rst_n; count clears, block arms, thr 3200, req 10.
// ----------------------------------------------------------------------------
// heading_alignment_debouncer_top: yaw alignment debounce
// Camera yaw and path yaw by atan2, wrapped error, consecutive-match pulse.
// ----------------------------------------------------------------------------
module heading_alignment_debouncer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  hadb_in_if.sink                            in_ch,
  hadb_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [hadb_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [hadb_pkg::CFG_W-1:0]         cfg_data
);
  import hadb_pkg::*;

  // config registers, to be written by the user only while idle; no logic enforces it
  cfg_t     cfg_r;
  qent_t    q_din, q_head;
  logic     q_push, q_full, q_pop, q_valid;
  cor_req_t cor_req;
  cor_rsp_t cor_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr <= THR_RESET;
      cfg_r.req <= REQ_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_MATCH_THRESHOLD) begin
        cfg_r.thr <= cfg_data[ERR_W-1:0];
      end
      if (cfg_idx == CFG_REQUIRED_MATCHES) begin
        cfg_r.req <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // front: accept beats and form the two vectors
  hadb_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_din  (q_din)
  );

  // short queue lets the front keep taking beats while the back works
  hadb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (q_head)
  );

  // shared atan2 unit, used once for camera yaw and once for path yaw
  hadb_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .rsp   (cor_rsp)
  );

  // back: sequencing, debounce state, output register
  hadb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .cfg     (cfg_r),
    .cor_req (cor_req),
    .cor_rsp (cor_rsp),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/hadb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hadb_checker: port-level checks of the result channel
// Result beat hold, pulse disarm and value ranges of the debouncer output.
// ----------------------------------------------------------------------------
module hadb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] camera_yaw,
  input logic [15:0] path_yaw,
  input logic [14:0] heading_error,
  input logic        aligned_pulse,
  input logic        armed,
  input logic [3:0]  match_count
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({camera_yaw, path_yaw, heading_error,
                                         aligned_pulse, armed, match_count}))
    else $error("result beat changed while stalled");

  a_pulse_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && aligned_pulse |-> !armed && match_count != 4'd0)
    else $error("alignment pulse without disarm");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> camera_yaw < 16'd46080 && path_yaw < 16'd46080 &&
                  heading_error <= 15'd23040)
    else $error("angle out of range");

endmodule

bind heading_alignment_debouncer_top hadb_checker u_hadb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .camera_yaw    (out_ch.camera_yaw),
  .path_yaw      (out_ch.path_yaw),
  .heading_error (out_ch.heading_error),
  .aligned_pulse (out_ch.aligned_pulse),
  .armed         (out_ch.armed),
  .match_count   (out_ch.match_count)
);
`default_nettype wire

// ----- tb/heading_alignment_debouncer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_alignment_debouncer_top_tb: self-checking bench for the yaw debouncer
// Drives pose and clear beats through a valid/ready channel and programs the
// threshold and match count between phases. A local model computes both CORDIC
// yaws, the wrapped error and the debounce state, and every result beat is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module heading_alignment_debouncer_top_tb;

  // Request codes on the req_type field
  localparam logic REQ_EVALUATE = 1'b0;
  localparam logic REQ_CLEAR    = 1'b1;

  // Angle scale: Q9.7 degrees; accumulator is Q.16 degrees
  localparam int     DEG360_Q7   = 46080;
  localparam int     DEG180_Q7   = 23040;
  localparam longint DEG180_Q16  = longint'(180) <<< 16;
  localparam longint DEG360_Q16  = longint'(360) <<< 16;
  localparam longint NORM_MAG    = longint'(1) <<< 49;
  localparam int     TAB_DEPTH   = 24;
  localparam int     ROTATIONS   = (hadb_pkg::CORDIC_STEPS < TAB_DEPTH) ?
                                   hadb_pkg::CORDIC_STEPS : TAB_DEPTH;
  localparam int     SEXT_SHIFT  = 64 - hadb_pkg::POS_WIDTH;
  localparam int     RUN_CEILING = 15;

  // Run shape
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int IDLE_PCT     = 32;
  localparam int HOLD_AT_BEAT = 700;   // receiver stalls once after this many results
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int QUIET_LIMIT  = 5000;  // cycles with no beat and no register write

  // arctan(2^-i) in Q.16 degrees, rounded
  localparam longint ARCTAN_Q16 [TAB_DEPTH] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_z;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_z;
  } pose_t;

  typedef struct packed {
    logic [hadb_pkg::ANG_W-1:0] camera_yaw;
    logic [hadb_pkg::ANG_W-1:0] path_yaw;
    logic [hadb_pkg::ERR_W-1:0] heading_error;
    logic                       aligned_pulse;
    logic                       armed;
    logic [hadb_pkg::CNT_W-1:0] match_count;
  } result_t;

  // One directed step: the beat, and the result when it is obvious by hand
  typedef struct packed {
    logic               req_type;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_z;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_z;
    logic               known;
    logic [15:0]        cy;
    logic [15:0]        py;
    logic [14:0]        err;
    logic               pulse;
    logic               armed;
    logic [3:0]         cnt;
  } step_row_t;

  typedef enum int {SHAPE_ALIGNED, SHAPE_NOISE, SHAPE_TINY, SHAPE_CLEAR} pose_shape_t;

  // Directed steps, default registers (25 deg threshold, 10 matches).
  // A zero forward vector with coincident points gives both yaws 0, so the
  // error is 0 and every such sample counts: ten of them fire the pulse, the
  // next one shows the count held while disarmed.
  localparam int N_DIRECTED = 23;
  localparam step_row_t DIRECTED_STEPS [N_DIRECTED] = '{
    '{REQ_CLEAR, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd0},
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd1},
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
      32'h8000_0000, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd2},
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd3},
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h7FFF_FFFF, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd4},
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h8000_0000, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd5},
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
      32'hFFFF_0000, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd6},
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'h1234_5678, 32'hEDCB_A987, 32'h1234_5678,
      32'hEDCB_A987, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd7},
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd8},
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hAAAA_AAAA, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd9},
    // tenth match: pulse, disarm
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h5555_5555, 1'b1, 16'd0, 16'd0, 15'd0, 1'b1, 1'b0, 4'd10},
    // disarmed: a zero error neither counts nor re-arms, count holds
    '{REQ_EVALUATE, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd10},
    // forward +x (90 deg) against a zero path: large error re-arms
    '{REQ_EVALUATE, 16'hC000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0},
    // field extremes, widest position span
    '{REQ_EVALUATE, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0},
    '{REQ_EVALUATE, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h8000_0000, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0},
    // cardinal headings: 0, 180 and 270 deg, both vectors agreeing
    '{REQ_EVALUATE, 16'h0000, 16'h8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0001, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0},
    '{REQ_EVALUATE, 16'h0000, 16'h7FFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0},
    '{REQ_EVALUATE, 16'h7FFF, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000,
      32'h0000_0000, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0},
    // 0 deg camera, 90 deg path
    '{REQ_EVALUATE, 16'h0000, 16'hC000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
      32'h0000_0000, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0},
    // opposite headings: error at its 180 deg ceiling
    '{REQ_EVALUATE, 16'h0000, 16'h8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h8000_0000, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0},
    // clear with every payload bit set: payload is ignored
    '{REQ_CLEAR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 1'b1, 16'd0, 16'd0, 15'd0, 1'b0, 1'b1, 4'd0},
    // 90 vs 270 deg with a 33-bit position difference
    '{REQ_EVALUATE, 16'h8000, 16'h0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000,
      32'h0000_0000, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0},
    // unit-sized vectors: deepest normalization
    '{REQ_EVALUATE, 16'h0001, 16'hFFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 1'b0, 16'd0, 16'd0, 15'd0, 1'b0, 1'b0, 4'd0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  hadb_pkg::cfg_idx_t     cfg_idx;
  logic [hadb_pkg::CFG_W-1:0] cfg_data;

  hadb_in_if  in_bus ();
  hadb_out_if out_bus ();

  heading_alignment_debouncer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Local copy of the block's registers and debounce state
  int  thr_q7;
  int  need_matches;
  int  run_len;
  bit  armed_now;

  result_t due_results [$];   // predictions, oldest first
  int      mismatches;
  bit      calm;              // no idling on either side while set
  bit      has_target;
  pose_t   target_pose;       // pose whose error equals the programmed threshold

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sign-extend a position from its low POS_WIDTH bits
  function automatic longint pos_ext(logic [31:0] v);
    longint w;
    w = longint'($signed(v));
    return (w <<< SEXT_SHIFT) >>> SEXT_SHIFT;
  endfunction

  // Vectoring CORDIC atan2: s on the sine side, c on the cosine side.
  // Returns Q9.7 degrees in [0, 360).
  function automatic int bearing_q7(longint s, longint c);
    longint x, y, acc, t;
    if (s == 0 && c == 0) return 0;
    x = c;
    y = s;
    acc = 0;
    // scale up until one component reaches 2^49
    while ((x < 0 ? -x : x) < NORM_MAG && (y < 0 ? -y : y) < NORM_MAG) begin
      x = x * 2;
      y = y * 2;
    end
    // left half plane: turn by 180 deg first
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = DEG180_Q16;
    end
    // >>> on longint floors, as the hardware does
    for (int i = 0; i < ROTATIONS; i++) begin
      if (y > 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        acc = acc + ARCTAN_Q16[i];
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        acc = acc - ARCTAN_Q16[i];
      end
      x = t;
    end
    if (acc < 0) acc = acc + DEG360_Q16;
    acc = (acc + 256) >>> 9;          // Q.16 -> Q9.7, round half up
    if (acc >= DEG360_Q7) acc = acc - DEG360_Q7;
    return int'(acc);
  endfunction

  // Yaws and wrapped error of a pose; the debounce fields stay zero
  function automatic result_t measure(pose_t p);
    result_t m;
    int      cy, py, gap;
    m = '0;
    cy = bearing_q7(-longint'($signed(p.rot_x)), -longint'($signed(p.rot_z)));
    py = bearing_q7(pos_ext(p.goal_x) - pos_ext(p.cam_x),
                    pos_ext(p.goal_z) - pos_ext(p.cam_z));
    gap = (cy > py) ? cy - py : py - cy;
    if (gap > DEG180_Q7) gap = DEG360_Q7 - gap;
    m.camera_yaw    = cy[15:0];
    m.path_yaw      = py[15:0];
    m.heading_error = gap[14:0];
    return m;
  endfunction

  // Advance the debounce state by one beat and return the result it causes
  function automatic result_t debounce_step(pose_t p);
    result_t r;
    int      gap;
    r = '0;
    if (p.req_type == REQ_CLEAR) begin
      run_len = 0;
      armed_now = 1'b1;
    end else begin
      r = measure(p);
      gap = r.heading_error;
      if (armed_now) begin
        if (gap < thr_q7) begin
          if (run_len < RUN_CEILING) run_len++;
          if (run_len >= need_matches || run_len >= RUN_CEILING) begin
            armed_now = 1'b0;
            r.aligned_pulse = 1'b1;
          end
        end else begin
          run_len = 0;          // includes an error equal to the threshold
        end
      end else if (gap > thr_q7) begin
        armed_now = 1'b1;
        run_len = 0;
      end
    end
    r.armed = armed_now;
    r.match_count = run_len[3:0];
    return r;
  endfunction

  // Random pose. Aligned poses point the path along a perturbed copy of the
  // forward vector, with the perturbation spanning a fraction of a degree up
  // to tens of degrees so the error lands on both sides of the threshold.
  function automatic pose_t draw_pose(pose_shape_t shape);
    pose_t  p;
    longint fx, fz, nx, nz, k, amp;
    p.req_type = REQ_EVALUATE;
    p.rot_x  = 16'($urandom);
    p.rot_z  = 16'($urandom);
    p.cam_x  = $urandom;
    p.cam_z  = $urandom;
    p.goal_x = $urandom;
    p.goal_z = $urandom;
    case (shape)
      SHAPE_CLEAR: p.req_type = REQ_CLEAR;
      SHAPE_TINY: begin
        p.rot_x  = 16'($urandom_range(0, 6) - 3);
        p.rot_z  = 16'($urandom_range(0, 6) - 3);
        p.goal_x = p.cam_x + 32'($urandom_range(0, 6) - 3);
        p.goal_z = p.cam_z + 32'($urandom_range(0, 6) - 3);
      end
      SHAPE_ALIGNED: begin
        fx  = -longint'($signed(p.rot_x));
        fz  = -longint'($signed(p.rot_z));
        k   = $urandom_range(1, 1 << $urandom_range(0, 13));
        amp = $urandom_range(0, 1 << $urandom_range(2, 15));
        nx  = longint'($urandom_range(0, 32'(2 * amp))) - amp;
        nz  = longint'($urandom_range(0, 32'(2 * amp))) - amp;
        // camera within +-2^30 and path within +-2^29: goal stays in range
        p.cam_x  = $signed($urandom) >>> 1;
        p.cam_z  = $signed($urandom) >>> 1;
        p.goal_x = 32'(longint'(p.cam_x) + (fx + nx) * k);
        p.goal_z = 32'(longint'(p.cam_z) + (fz + nz) * k);
      end
      default: ;
    endcase
    return p;
  endfunction

  // Offer one beat, wait for it to be taken, then queue its prediction.
  // A typed expectation replaces the prediction but the state still advances.
  task automatic offer(pose_t p, bit typed, result_t typed_want);
    result_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.req_type   <= p.req_type;
    in_bus.rot_elem_x <= p.rot_x;
    in_bus.rot_elem_z <= p.rot_z;
    in_bus.cam_x      <= p.cam_x;
    in_bus.cam_z      <= p.cam_z;
    in_bus.goal_x     <= p.goal_x;
    in_bus.goal_z     <= p.goal_z;
    do @(posedge clk); while (!in_bus.ready);
    predicted = debounce_step(p);
    due_results.push_back(typed ? typed_want : predicted);
  endtask

  // Both registers in back-to-back cycles; the enable drops once at the end
  task automatic program_regs(int thr, int need);
    cfg_we   <= 1'b1;
    cfg_idx  <= hadb_pkg::CFG_MATCH_THRESHOLD;
    cfg_data <= 15'(thr);
    @(posedge clk);
    cfg_idx  <= hadb_pkg::CFG_REQUIRED_MATCHES;
    cfg_data <= 15'(need);
    @(posedge clk);
    cfg_we   <= 1'b0;
    thr_q7       = thr & 'h7FFF;
    need_matches = need & 'hF;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: reset, the directed table, then randomized phases, each with its
  // own register setting. Registers change only once every result is back.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    step_row_t row;
    pose_t     p;
    result_t   want, probe, blank_result;
    int        thr, need, sent, pick;

    blank_result = '0;
    mismatches   = 0;
    calm         = 1'b0;
    has_target   = 1'b0;
    target_pose  = '0;

    // every input known from time zero
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= hadb_pkg::CFG_MATCH_THRESHOLD;
    cfg_data          <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.req_type   <= REQ_EVALUATE;
    in_bus.rot_elem_x <= '0;
    in_bus.rot_elem_z <= '0;
    in_bus.cam_x      <= '0;
    in_bus.cam_z      <= '0;
    in_bus.goal_x     <= '0;
    in_bus.goal_z     <= '0;

    // reset values: 25 deg threshold, 10 matches, armed, count zero
    thr_q7       = 3200;
    need_matches = 10;
    run_len      = 0;
    armed_now    = 1'b1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_STEPS[i];
      p = '{row.req_type, row.rot_x, row.rot_z, row.cam_x, row.cam_z,
            row.goal_x, row.goal_z};
      want = '{row.cy, row.py, row.err, row.pulse, row.armed, row.cnt};
      offer(p, row.known, want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // sender pauses until the block has drained, then reprograms it
      in_bus.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clk);
      @(posedge clk);

      has_target = 1'b0;
      calm = 1'b0;
      case (phase)
        0: begin                      // zero threshold: nothing ever matches
          thr = 0;
          need = 7;
        end
        1: begin                      // 180 deg threshold, longest run
          thr = DEG180_Q7;
          need = 15;
        end
        2: begin
          // threshold equal to one pose's own error, so repeats of that pose
          // sit exactly on the boundary in both armed and disarmed states
          do begin
            target_pose = draw_pose(SHAPE_ALIGNED);
            probe = measure(target_pose);
          end while (probe.heading_error < 1280 || probe.heading_error > 6400);
          thr = probe.heading_error;
          need = $urandom_range(1, 6);
          has_target = 1'b1;
        end
        3: begin                      // zero required: first match fires
          thr = $urandom_range(1600, 8000);
          need = 0;
        end
        4: begin                      // all-ones threshold field
          thr = 'h7FFF;
          need = 1;
        end
        5: begin                      // reset values, no idling on either side
          thr = 3200;
          need = 10;
          calm = 1'b1;
        end
        6: begin
          thr = $urandom_range(0, DEG180_Q7);
          need = $urandom_range(0, 15);
        end
        default: begin
          thr = 1280;
          need = 3;
        end
      endcase
      program_regs(thr, need);

      // Bursts of aligned poses build match runs; each burst ends with a
      // clear, tiny vectors, boundary poses or pure noise.
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        repeat ($urandom_range(1, 18)) begin
          if (has_target && $urandom_range(0, 9) == 0) p = target_pose;
          else p = draw_pose(SHAPE_ALIGNED);
          offer(p, 1'b0, blank_result);
          sent++;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) p = draw_pose(SHAPE_CLEAR);
        else if (pick < 3) p = draw_pose(SHAPE_TINY);
        else if (pick < 6 && has_target) p = target_pose;
        else p = draw_pose(SHAPE_NOISE);
        offer(p, 1'b0, blank_result);
        sent++;
      end
    end

    in_bus.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // let any stray beat show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("heading_alignment_debouncer_top_tb passed");
    end else begin
      $display("heading_alignment_debouncer_top_tb failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: compares each beat with the oldest prediction and drives
  // ready. After HOLD_AT_BEAT results it holds ready low until its hold count
  // runs out, so the block backs up and stops taking pose beats.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    result_t got, want;
    int      seen, hold;
    seen = 0;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.camera_yaw, out_bus.path_yaw, out_bus.heading_error,
                out_bus.aligned_pulse, out_bus.armed, out_bus.match_count};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result beat, camera_yaw %0d path_yaw %0d",
                   $time, got.camera_yaw, got.path_yaw);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("camera_yaw", want.camera_yaw, got.camera_yaw);
          check_field("path_yaw", want.path_yaw, got.path_yaw);
          check_field("heading_error", want.heading_error, got.heading_error);
          check_field("aligned_pulse", want.aligned_pulse, got.aligned_pulse);
          check_field("armed", want.armed, got.armed);
          check_field("match_count", want.match_count, got.match_count);
        end
        seen++;
        if (seen == HOLD_AT_BEAT) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: too long without any beat or register write means a hang
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("heading_alignment_debouncer_top_tb failed");
        $finish;
      end
    end
  end

endmodule
